// ----- rtl/fbp_pkg.sv -----
// ----------------------------------------------------------------------------
// fbp_pkg
// shared types and constants of the fixed block pool with its free ring
// ----------------------------------------------------------------------------
package fbp_pkg;

    localparam int DATA_W    = 32;  // addresses and dividends
    localparam int AUX_W     = 17;  // stride or pool size, the divisor side
    localparam int SIZE_W    = 16;
    localparam int PCNT_W    = 11;
    localparam int STATUS_W  = 3;
    localparam int KIND_W    = 2;
    localparam int BIDX_W    = 10;
    localparam int LEFT_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 5;

    localparam int MUL_STEPS = AUX_W;   // one multiplier bit a cycle
    localparam int DIV_STEPS = DATA_W;  // one quotient bit a cycle

    localparam int BASE_RST       = 0;
    localparam int ITEM_SIZE_RST  = 64;
    localparam int POOL_COUNT_RST = 1024;
    localparam int STRIDE_EXTRA   = 4;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFILL = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOREIGN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REFILL  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // shared arithmetic unit operations
    typedef logic [2:0] t_aop;
    localparam t_aop AOP_HOLD  = 3'd0;
    localparam t_aop AOP_LOAD  = 3'd1;  // acc <= a, quo <= b, aux <= d
    localparam t_aop AOP_DIFF  = 3'd2;  // quo <= a - b, acc <= 0, aux <= d
    localparam t_aop AOP_SUM   = 3'd3;  // quo <= a + b, acc <= 0, aux <= d
    localparam t_aop AOP_MSTEP = 3'd4;  // shift-add multiply step
    localparam t_aop AOP_DSTEP = 3'd5;  // restoring divide step

    typedef struct packed {
        t_aop              op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [AUX_W-1:0]  d;
    } t_arith_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] acc;  // product, or remainder in the low bits
        logic [DATA_W-1:0] quo;  // quotient
    } t_arith_res;

endpackage

// ----- rtl/fbp_arith.sv -----
// ----------------------------------------------------------------------------
// fbp_arith
// shared add/subtract unit with shift-add multiply and restoring divide steps
// ----------------------------------------------------------------------------
module fbp_arith (
    input  logic                i_clk,
    input  fbp_pkg::t_arith_cmd i_cmd,
    output fbp_pkg::t_arith_res o_res
);

    logic [fbp_pkg::DATA_W-1:0] r_acc, n_acc;
    logic [fbp_pkg::DATA_W-1:0] r_quo, n_quo;
    logic [fbp_pkg::AUX_W-1:0]  r_aux, n_aux;
    logic [fbp_pkg::DATA_W:0]   w_x, w_y, w_sum;
    logic                       w_sub;

    // the one adder
    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_sub = 1'b0;
        unique case (i_cmd.op)
            fbp_pkg::AOP_DIFF: begin
                w_x   = {1'b0, i_cmd.a};
                w_y   = {1'b0, i_cmd.b};
                w_sub = 1'b1;
            end
            fbp_pkg::AOP_SUM: begin
                w_x = {1'b0, i_cmd.a};
                w_y = {1'b0, i_cmd.b};
            end
            fbp_pkg::AOP_MSTEP: begin
                w_x = {1'b0, r_acc};
                w_y = {1'b0, r_quo};
            end
            fbp_pkg::AOP_DSTEP: begin
                // partial remainder shifted, next dividend bit in
                w_x   = {15'b0, r_acc[fbp_pkg::AUX_W-1:0], r_quo[fbp_pkg::DATA_W-1]};
                w_y   = {16'b0, r_aux};
                w_sub = 1'b1;
            end
            default: ;
        endcase
        w_sum = w_x + (w_y ^ {(fbp_pkg::DATA_W+1){w_sub}}) + {32'b0, w_sub};
    end

    always_comb begin
        n_acc = r_acc;
        n_quo = r_quo;
        n_aux = r_aux;
        unique case (i_cmd.op)
            fbp_pkg::AOP_LOAD: begin
                n_acc = i_cmd.a;
                n_quo = i_cmd.b;
                n_aux = i_cmd.d;
            end
            fbp_pkg::AOP_DIFF, fbp_pkg::AOP_SUM: begin
                n_acc = '0;
                n_quo = w_sum[fbp_pkg::DATA_W-1:0];
                n_aux = i_cmd.d;
            end
            fbp_pkg::AOP_MSTEP: begin
                if (r_aux[0]) begin
                    n_acc = w_sum[fbp_pkg::DATA_W-1:0];
                end
                n_quo = {r_quo[fbp_pkg::DATA_W-2:0], 1'b0};
                n_aux = r_aux >> 1;
            end
            fbp_pkg::AOP_DSTEP: begin
                // sign bit of the trial difference decides the quotient bit
                if (!w_sum[fbp_pkg::DATA_W]) begin
                    n_acc = {15'b0, w_sum[fbp_pkg::AUX_W-1:0]};
                    n_quo = {r_quo[fbp_pkg::DATA_W-2:0], 1'b1};
                end else begin
                    n_acc = {15'b0, r_acc[fbp_pkg::AUX_W-2:0], r_quo[fbp_pkg::DATA_W-1]};
                    n_quo = {r_quo[fbp_pkg::DATA_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_aux <= n_aux;
    end

    assign o_res.acc = r_acc;
    assign o_res.quo = r_quo;

endmodule

// ----- rtl/fbp_ring.sv -----
// ----------------------------------------------------------------------------
// fbp_ring
// free ring storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fbp_ring #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fixed_block_pool_free_ring.sv -----
// ----------------------------------------------------------------------------
// fixed_block_pool_free_ring
// allocator for a pool of equal-sized blocks kept in a circular free ring
// ----------------------------------------------------------------------------
// usage
//   input words (i_in_valid / o_in_stall) carry a kind and, for a free, the
//   byte address of the block; each accepted allocate, free or refill gives
//   exactly one output word (o_out_valid / i_out_stall); kind 3 is swallowed
//   configuration words (i_cfg_valid / o_cfg_ready) set base address, item
//   size and pool count; ready is always high, write only while idle
//   one word is worked on at a time, o_in_stall is high until it is done
//   steps from accept to result:
//     allocate  ring read, 17 shift-add multiply steps for
//               base + index * stride, 32 divide steps for the head wrap
//     free      two 32-step divides, address to index and
//               the tail slot modulo the pool size
//     refill    one ring entry written per cycle
//     empty answers, and foreign answers found at accept, skip these steps
//   allocate and free run these steps on the shared add/subtract unit
//   after reset the ring is loaded with its identity list, during which
//   o_in_stall stays high (configuration is still taken)
//   a stalled result holds in the output register; the block then waits
//   before presenting the next result, but may take the next input word
// ----------------------------------------------------------------------------
module fixed_block_pool_free_ring #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fbp_pkg::KIND_W-1:0]      i_kind,
    input  logic [fbp_pkg::DATA_W-1:0]      i_address,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fbp_pkg::STATUS_W-1:0]    o_status,
    output logic [fbp_pkg::DATA_W-1:0]      o_block_address,
    output logic [fbp_pkg::BIDX_W-1:0]      o_block_index,
    output logic [fbp_pkg::LEFT_W-1:0]      o_free_left,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbp_pkg::DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int RST_FREE = (fbp_pkg::POOL_COUNT_RST > POOL_DEPTH) ?
                              POOL_DEPTH : fbp_pkg::POOL_COUNT_RST;

    // sequencer states
    localparam logic [3:0] S_INIT  = 4'd0;   // identity load after reset
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ARD   = 4'd2;   // ring read of the head entry
    localparam logic [3:0] S_MUL   = 4'd3;   // base + index * stride
    localparam logic [3:0] S_AMOD  = 4'd4;   // head + 1
    localparam logic [3:0] S_ADIV  = 4'd5;   // ... modulo pool size
    localparam logic [3:0] S_AUPD  = 4'd6;
    localparam logic [3:0] S_FDIV  = 4'd7;   // offset / stride
    localparam logic [3:0] S_FCHK  = 4'd8;   // range check, head + count
    localparam logic [3:0] S_FDIV2 = 4'd9;   // ... modulo pool size
    localparam logic [3:0] S_FWR   = 4'd10;  // ring write at the tail
    localparam logic [3:0] S_FILL  = 4'd11;  // refill walk
    localparam logic [3:0] S_RESP  = 4'd12;  // hand over to output register

    // configuration registers
    logic [fbp_pkg::DATA_W-1:0]   r_base;
    logic [fbp_pkg::SIZE_W-1:0]   r_item_size;
    logic [fbp_pkg::PCNT_W-1:0]   r_pool_count;

    // pool state
    logic [IDX_W-1:0]             r_head, n_head;
    logic [CNT_W-1:0]             r_fc, n_fc;

    // sequencer
    logic [3:0]                   r_state, n_state;
    logic [fbp_pkg::STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]             r_cnt, n_cnt;

    // pending result
    logic [fbp_pkg::STATUS_W-1:0] r_st, n_st;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [fbp_pkg::DATA_W-1:0]   r_baddr, n_baddr;

    // output register
    logic                         r_out_valid;
    logic [fbp_pkg::STATUS_W-1:0] r_o_status;
    logic [fbp_pkg::DATA_W-1:0]   r_o_baddr;
    logic [fbp_pkg::BIDX_W-1:0]   r_o_bidx;
    logic [fbp_pkg::LEFT_W-1:0]   r_o_left;

    // derived values
    logic [fbp_pkg::DATA_W-1:0]   w_pc32, w_n32, w_idx32, w_fc32;
    logic [CNT_W-1:0]             w_n;
    logic [fbp_pkg::AUX_W-1:0]    w_n17, w_stride;
    logic                         w_in_acc, w_load_out, w_cfg_we;
    logic                         w_step_last_mul, w_step_last_div;

    // ring port
    logic                         w_ring_we;
    logic [IDX_W-1:0]             w_ring_waddr, w_ring_wdata, w_ring_rdata;

    // shared unit
    fbp_pkg::t_arith_cmd          w_cmd;
    fbp_pkg::t_arith_res          w_res;

    // effective pool size, saturated to the ring depth
    assign w_pc32   = 32'(r_pool_count);
    assign w_n32    = (w_pc32 > 32'(POOL_DEPTH)) ? 32'(POOL_DEPTH) : w_pc32;
    assign w_n      = w_n32[CNT_W-1:0];
    assign w_n17    = w_n32[fbp_pkg::AUX_W-1:0];
    assign w_stride = 17'(r_item_size) + 17'(fbp_pkg::STRIDE_EXTRA);
    assign w_fc32   = 32'(r_fc);
    assign w_idx32  = 32'(r_idx);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load_out = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    assign w_step_last_mul = (r_step == fbp_pkg::STEP_W'(fbp_pkg::MUL_STEPS - 1));
    assign w_step_last_div = (r_step == fbp_pkg::STEP_W'(fbp_pkg::DIV_STEPS - 1));

    fbp_arith u_arith (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .o_res (w_res)
    );

    fbp_ring #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_ring_wdata),
        .i_raddr (r_head),
        .o_rdata (w_ring_rdata)
    );

    // ring writes: identity walk, or a freed index at the tail slot
    always_comb begin
        w_ring_we    = 1'b0;
        w_ring_waddr = r_cnt[IDX_W-1:0];
        w_ring_wdata = r_cnt[IDX_W-1:0];
        if ((r_state == S_INIT) || (r_state == S_FILL)) begin
            w_ring_we = 1'b1;
        end else if (r_state == S_FWR) begin
            w_ring_we    = 1'b1;
            w_ring_waddr = w_res.acc[IDX_W-1:0];
            w_ring_wdata = r_idx;
        end
    end

    // sequencer and commands to the shared unit
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_fc    = r_fc;
        n_st    = r_st;
        n_idx   = r_idx;
        n_baddr = r_baddr;
        w_cmd   = '{op: fbp_pkg::AOP_HOLD, a: '0, b: '0, d: '0};

        unique case (r_state)
            S_INIT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(POOL_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_step = '0;
                    n_cnt  = '0;
                    priority if (i_kind == fbp_pkg::KIND_ALLOC) begin
                        if ((r_fc == '0) || (w_n == '0)) begin
                            n_st    = fbp_pkg::ST_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_ARD;
                        end
                    end else if (i_kind == fbp_pkg::KIND_FREE) begin
                        // offset from the pool base, wrapping
                        w_cmd = '{op: fbp_pkg::AOP_DIFF, a: i_address, b: r_base,
                                  d: w_stride};
                        if ((w_n == '0) || (w_fc32 >= w_n32)) begin
                            n_st    = fbp_pkg::ST_FOREIGN;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_FDIV;
                        end
                    end else if (i_kind == fbp_pkg::KIND_REFILL) begin
                        if (w_n == '0) begin
                            n_fc    = '0;
                            n_st    = fbp_pkg::ST_REFILL;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_FILL;
                        end
                    end else begin
                        n_state = S_IDLE;  // unused kind, no result
                    end
                end
            end
            S_ARD: begin
                n_idx = w_ring_rdata;
                w_cmd = '{op: fbp_pkg::AOP_LOAD, a: r_base,
                          b: 32'(w_ring_rdata), d: w_stride};
                n_state = S_MUL;
            end
            S_MUL: begin
                w_cmd.op = fbp_pkg::AOP_MSTEP;
                n_step   = r_step + 1'b1;
                if (w_step_last_mul) begin
                    n_step  = '0;
                    n_state = S_AMOD;
                end
            end
            S_AMOD: begin
                n_baddr = w_res.acc;
                w_cmd   = '{op: fbp_pkg::AOP_SUM, a: 32'(r_head), b: 32'd1, d: w_n17};
                n_state = S_ADIV;
            end
            S_ADIV, S_FDIV, S_FDIV2: begin
                w_cmd.op = fbp_pkg::AOP_DSTEP;
                n_step   = r_step + 1'b1;
                if (w_step_last_div) begin
                    n_step = '0;
                    unique case (r_state)
                        S_ADIV:  n_state = S_AUPD;
                        S_FDIV:  n_state = S_FCHK;
                        default: n_state = S_FWR;
                    endcase
                end
            end
            S_AUPD: begin
                n_head  = w_res.acc[IDX_W-1:0];
                n_fc    = r_fc - 1'b1;
                n_st    = fbp_pkg::ST_ALLOC;
                n_state = S_RESP;
            end
            S_FCHK: begin
                if (w_res.quo < w_n32) begin
                    n_idx   = w_res.quo[IDX_W-1:0];
                    // tail slot = (head + count) mod n
                    w_cmd   = '{op: fbp_pkg::AOP_SUM, a: 32'(r_head), b: w_fc32,
                                d: w_n17};
                    n_state = S_FDIV2;
                end else begin
                    n_st    = fbp_pkg::ST_FOREIGN;
                    n_state = S_RESP;
                end
            end
            S_FWR: begin
                n_fc    = r_fc + 1'b1;
                n_st    = fbp_pkg::ST_FREED;
                n_state = S_RESP;
            end
            S_FILL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (w_n - 1'b1)) begin
                    n_cnt   = '0;
                    n_fc    = w_n;
                    n_st    = fbp_pkg::ST_REFILL;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_step       <= '0;
            r_cnt        <= '0;
            r_head       <= '0;
            r_fc         <= CNT_W'(RST_FREE);
            r_out_valid  <= 1'b0;
            r_base       <= 32'(fbp_pkg::BASE_RST);
            r_item_size  <= fbp_pkg::SIZE_W'(fbp_pkg::ITEM_SIZE_RST);
            r_pool_count <= fbp_pkg::PCNT_W'(fbp_pkg::POOL_COUNT_RST);
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_fc    <= n_fc;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    fbp_pkg::CFG_BASE:  r_base       <= i_cfg_data;
                    fbp_pkg::CFG_SIZE:  r_item_size  <= i_cfg_data[fbp_pkg::SIZE_W-1:0];
                    fbp_pkg::CFG_COUNT: r_pool_count <= i_cfg_data[fbp_pkg::PCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_st    <= n_st;
        r_idx   <= n_idx;
        r_baddr <= n_baddr;
        if (w_load_out) begin
            r_o_status <= r_st;
            r_o_baddr  <= (r_st == fbp_pkg::ST_ALLOC) ? r_baddr : '0;
            r_o_bidx   <= ((r_st == fbp_pkg::ST_ALLOC) || (r_st == fbp_pkg::ST_FREED)) ?
                          w_idx32[fbp_pkg::BIDX_W-1:0] : '0;
            r_o_left   <= w_fc32[fbp_pkg::LEFT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_block_address = r_o_baddr;
    assign o_block_index   = r_o_bidx;
    assign o_free_left     = r_o_left;

`ifndef NO_ASSERTIONS
    // free count never exceeds the ring
    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fc32 <= 32'(POOL_DEPTH)))
        else $error("free count beyond ring depth");

    // head pointer always addresses a ring entry
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_head) < 32'(POOL_DEPTH)))
        else $error("head pointer beyond ring depth");

    // modulo result lies inside the pool when used
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_AUPD) || (r_state == S_FWR)) |-> (w_res.acc < w_n32))
        else $error("ring slot outside pool");

    // a result is only loaded from the hand-over state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> ($past(r_state) == S_RESP))
        else $error("result presented without hand-over");
`endif

endmodule
